// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/lcm_pkg.sv
`timescale 1ns / 1ps

package lcm_pkg;

   localparam int MULTIPLE_BITS = 48;
   localparam int PC_BITS       = 3;

   // Program steps
   localparam logic [PC_BITS-1:0] STEP_WAIT = 3'd0;
   localparam logic [PC_BITS-1:0] STEP_TEST = 3'd1;
   localparam logic [PC_BITS-1:0] STEP_MOD  = 3'd2;
   localparam logic [PC_BITS-1:0] STEP_SWAP = 3'd3;
   localparam logic [PC_BITS-1:0] STEP_QUO  = 3'd4;
   localparam logic [PC_BITS-1:0] STEP_MUL  = 3'd5;
   localparam logic [PC_BITS-1:0] STEP_PAIR = 3'd6;
   localparam logic [PC_BITS-1:0] STEP_EMIT = 3'd7;

   // Datapath operations
   localparam logic [2:0] OP_WAIT = 3'd0;
   localparam logic [2:0] OP_TEST = 3'd1;
   localparam logic [2:0] OP_DIV  = 3'd2;
   localparam logic [2:0] OP_SWAP = 3'd3;
   localparam logic [2:0] OP_MUL  = 3'd4;
   localparam logic [2:0] OP_PAIR = 3'd5;
   localparam logic [2:0] OP_EMIT = 3'd6;

   // Jump conditions
   localparam logic [2:0] COND_NEVER   = 3'd0;
   localparam logic [2:0] COND_ALWAYS  = 3'd1;
   localparam logic [2:0] COND_Y_ZERO  = 3'd2;
   localparam logic [2:0] COND_ZERO_OP = 3'd3;
   localparam logic [2:0] COND_MORE    = 3'd4;

   // Divider operand selection
   localparam logic SRC_X_BY_Y = 1'b0;
   localparam logic SRC_P_BY_G = 1'b1;

   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         cond;
      logic [PC_BITS-1:0] target;
      logic               src;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      unique case (pc)
         STEP_WAIT: w = '{op: OP_WAIT, cond: COND_ZERO_OP, target: STEP_EMIT, src: SRC_X_BY_Y};
         STEP_TEST: w = '{op: OP_TEST, cond: COND_Y_ZERO,  target: STEP_QUO,  src: SRC_X_BY_Y};
         STEP_MOD:  w = '{op: OP_DIV,  cond: COND_NEVER,   target: STEP_WAIT, src: SRC_X_BY_Y};
         STEP_SWAP: w = '{op: OP_SWAP, cond: COND_ALWAYS,  target: STEP_TEST, src: SRC_X_BY_Y};
         STEP_QUO:  w = '{op: OP_DIV,  cond: COND_NEVER,   target: STEP_WAIT, src: SRC_P_BY_G};
         STEP_MUL:  w = '{op: OP_MUL,  cond: COND_NEVER,   target: STEP_WAIT, src: SRC_X_BY_Y};
         STEP_PAIR: w = '{op: OP_PAIR, cond: COND_MORE,    target: STEP_TEST, src: SRC_X_BY_Y};
         STEP_EMIT: w = '{op: OP_EMIT, cond: COND_ALWAYS,  target: STEP_WAIT, src: SRC_X_BY_Y};
         default:   w = '{op: OP_WAIT, cond: COND_NEVER,   target: STEP_WAIT, src: SRC_X_BY_Y};
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/lcm_euclid_two_or_three.sv
`timescale 1ns / 1ps
// Least common multiple of two or three unsigned operands.
// Input channel req_*: operands a, b, c and use_three; a transaction is taken
// when req_valid is high and req_stall is low. req_stall is low only while the
// sequencer waits for work, also while a finished result is still held.
// Result channel rsp_*: rsp_multiple (48 bits) and rsp_zero_operand, one per
// input transaction, held in an output register until rsp_stall is low.
// A small microcode table steps a shared datapath: a restoring divider that
// retires one quotient bit a cycle (2*W bits, W = OPERAND_BITS) and a
// shift-add multiplier that takes one multiplier bit a cycle.
// Each operand pair runs Euclid remainder steps (divide x by y, then swap)
// until y is zero, then divides the pair's first operand by their gcd and
// multiplies the quotient by the second; three operands run two pairs, the
// second pairing lcm(a, b) with c. A zero operand skips all arithmetic: the
// sequencer jumps from its wait step to its emit step and answers 0 with the
// flag set. A new transaction is taken only after the last one is emitted.
// Reset returns the sequencer to its wait step and empties the output
// register. While the receiver stalls, the result holds; the block finishes
// the next transaction only up to its emit step and waits there.
`include "assert_macros.svh"

module lcm_euclid_two_or_three #(
   parameter int OPERAND_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [OPERAND_BITS-1:0]            req_operand_a,
   input  logic [OPERAND_BITS-1:0]            req_operand_b,
   input  logic [OPERAND_BITS-1:0]            req_operand_c,
   input  logic                               req_use_three,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lcm_pkg::MULTIPLE_BITS-1:0]  rsp_multiple,
   output logic                               rsp_zero_operand
);

   localparam int W        = OPERAND_BITS;
   localparam int DW       = 2 * OPERAND_BITS;
   localparam int MB       = lcm_pkg::MULTIPLE_BITS;
   localparam int CNT_BITS = $clog2(DW + 1);

   logic [lcm_pkg::PC_BITS-1:0] pc_ff, pc_in;
   lcm_pkg::ucode_type          uw;

   logic [DW-1:0]       x_ff, x_in;
   logic [W-1:0]        y_ff, y_in;
   logic [DW-1:0]       p_ff, p_in;
   logic [W-1:0]        q_ff, q_in;
   logic [W-1:0]        c_ff, c_in;
   logic                three_ff, three_in;
   logic                second_ff, second_in;
   logic                zero_ff, zero_in;

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]       quo_ff, quo_in;
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic [MB-1:0]       acc_ff, acc_in;
   logic [MB-1:0]       mcd_ff, mcd_in;
   logic [W-1:0]        mpl_ff, mpl_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [MB-1:0]       rsp_mult_ff, rsp_mult_in;
   logic                rsp_zero_ff, rsp_zero_in;

   logic                req_accept;
   logic                zero_req;
   logic                out_free;
   logic                cond_true;
   logic                step_done;
   logic                last_iter;
   logic [W:0]          trial;
   logic [W:0]          diff;
   logic                fits;

   assign uw         = lcm_pkg::ucode_rom(pc_ff);
   assign req_stall  = (uw.op != lcm_pkg::OP_WAIT);
   assign req_accept = req_valid && !req_stall;
   assign zero_req   = (req_operand_a == '0) || (req_operand_b == '0)
                       || (req_use_three && (req_operand_c == '0));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_iter  = busy_ff && (cnt_ff == CNT_BITS'(1));

   // Restoring divider: one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      unique case (uw.cond)
         lcm_pkg::COND_NEVER:   cond_true = 1'b0;
         lcm_pkg::COND_ALWAYS:  cond_true = 1'b1;
         lcm_pkg::COND_Y_ZERO:  cond_true = (y_ff == '0);
         lcm_pkg::COND_ZERO_OP: cond_true = zero_req;
         lcm_pkg::COND_MORE:    cond_true = three_ff && !second_ff;
         default:               cond_true = 1'b0;
      endcase
   end

   always_comb begin
      unique case (uw.op)
         lcm_pkg::OP_WAIT: step_done = req_accept;
         lcm_pkg::OP_DIV:  step_done = last_iter;
         lcm_pkg::OP_MUL:  step_done = last_iter;
         lcm_pkg::OP_EMIT: step_done = out_free;
         default:          step_done = 1'b1;
      endcase
   end

   always_comb begin
      pc_in        = pc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      c_in         = c_ff;
      three_in     = three_ff;
      second_in    = second_ff;
      zero_in      = zero_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      acc_in       = acc_ff;
      mcd_in       = mcd_ff;
      mpl_in       = mpl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mult_in  = rsp_mult_ff;
      rsp_zero_in  = rsp_zero_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (uw.op)
         lcm_pkg::OP_WAIT: begin
            if (req_accept) begin
               x_in      = DW'(req_operand_a);
               p_in      = DW'(req_operand_a);
               y_in      = req_operand_b;
               q_in      = req_operand_b;
               c_in      = req_operand_c;
               three_in  = req_use_three;
               second_in = 1'b0;
               zero_in   = zero_req;
               acc_in    = '0;
            end
         end
         lcm_pkg::OP_DIV: begin
            if (!busy_ff) begin
               busy_in = 1'b1;
               cnt_in  = CNT_BITS'(DW);
               rem_in  = '0;
               if (uw.src == lcm_pkg::SRC_P_BY_G) begin
                  quo_in = p_ff;
                  dvs_in = x_ff[W-1:0];
               end else begin
                  quo_in = x_ff;
                  dvs_in = y_ff;
               end
            end else begin
               rem_in = fits ? diff[W-1:0] : trial[W-1:0];
               quo_in = {quo_ff[DW-2:0], fits};
               cnt_in = cnt_ff - CNT_BITS'(1);
               if (last_iter) begin
                  busy_in = 1'b0;
               end
            end
         end
         lcm_pkg::OP_SWAP: begin
            x_in = DW'(y_ff);
            y_in = rem_ff;
         end
         lcm_pkg::OP_MUL: begin
            if (!busy_ff) begin
               busy_in = 1'b1;
               cnt_in  = CNT_BITS'(W);
               mcd_in  = MB'(quo_ff);
               mpl_in  = q_ff;
               acc_in  = '0;
            end else begin
               if (mpl_ff[0]) begin
                  acc_in = acc_ff + mcd_ff;
               end
               mcd_in = {mcd_ff[MB-2:0], 1'b0};
               mpl_in = {1'b0, mpl_ff[W-1:1]};
               cnt_in = cnt_ff - CNT_BITS'(1);
               if (last_iter) begin
                  busy_in = 1'b0;
               end
            end
         end
         lcm_pkg::OP_PAIR: begin
            // Fold lcm(a, b) into the second pair with c
            if (cond_true) begin
               x_in      = acc_ff[DW-1:0];
               p_in      = acc_ff[DW-1:0];
               y_in      = c_ff;
               q_in      = c_ff;
               second_in = 1'b1;
            end
         end
         lcm_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mult_in  = acc_ff;
               rsp_zero_in  = zero_ff;
            end
         end
         default: begin
         end
      endcase

      if (step_done) begin
         pc_in = cond_true ? uw.target : pc_ff + lcm_pkg::PC_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= lcm_pkg::STEP_WAIT;
         busy_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         busy_ff      <= busy_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      c_ff        <= c_in;
      three_ff    <= three_in;
      zero_ff     <= zero_in;
      cnt_ff      <= cnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      acc_ff      <= acc_in;
      mcd_ff      <= mcd_in;
      mpl_ff      <= mpl_in;
      rsp_mult_ff <= rsp_mult_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_multiple     = rsp_mult_ff;
   assign rsp_zero_operand = rsp_zero_ff;

   `ASSERT_NEXT(a_zero_to_emit, clock, reset, req_accept && zero_req,
                (pc_ff == lcm_pkg::STEP_EMIT) && zero_ff)
   `ASSERT_IMPLY(a_busy_in_unit, clock, reset, busy_ff,
                 (uw.op == lcm_pkg::OP_DIV) || (uw.op == lcm_pkg::OP_MUL))
   `ASSERT_IMPLY(a_lcm_nonzero, clock, reset, (uw.op == lcm_pkg::OP_EMIT) && !zero_ff,
                 acc_ff != '0)
   `ASSERT_IMPLY(a_second_needs_three, clock, reset, second_ff, three_ff)

endmodule
